// ----- rtl/csi_pkg.sv -----
// csi_pkg: shared constants for the CSR self-loop insertion block.
// No dependencies; used by the core.
package csi_pkg;

  localparam logic CMD_ENTRY = 1'b0;
  localparam logic CMD_EMPTY = 1'b1;

endpackage

// ----- rtl/csi_if.sv -----
// csi_in_if / csi_out_if: valid-ready channels for index items and result items.
// Depends on nothing; the widths follow the top-level parameters.
interface csi_in_if #(
  parameter int unsigned INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [INDEX_BITS-1:0] col;
  logic                  row_last;

  modport source (output valid, cmd, col, row_last, input ready);
  modport sink   (input valid, cmd, col, row_last, output ready);
endinterface

interface csi_out_if #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COUNT_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] out_col;
  logic                  row_end;
  logic [COUNT_BITS-1:0] row_pointer;
  logic                  matrix_end;
  logic                  last;

  modport source (output valid, out_col, row_end, row_pointer, matrix_end, last,
                  input ready);
  modport sink   (input valid, out_col, row_end, row_pointer, matrix_end, last,
                  output ready);
endinterface

// ----- rtl/csi_core.sv -----
// csi_core: row state, row-count register and result generation per transaction.
// Depends on csi_pkg for command codes.
module csi_core #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned RES_W      = INDEX_BITS + COUNT_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS:0]   cfg_wdata,
  input  logic                  accept,
  input  logic                  cmd,
  input  logic [INDEX_BITS-1:0] in_col,
  input  logic                  row_last,
  output logic [RES_W-1:0]      res0,
  output logic [RES_W-1:0]      res1,
  output logic                  two
);

  localparam logic [INDEX_BITS:0] ROWS_MAX = {1'b1, {INDEX_BITS{1'b0}}};
  localparam logic [INDEX_BITS:0] ROWS_ONE = {{INDEX_BITS{1'b0}}, 1'b1};
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [INDEX_BITS:0]   num_rows_r;
  logic [INDEX_BITS-1:0] row_r, row_nxt;
  logic                  seen_r, seen_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [INDEX_BITS:0]   eff_rows;
  logic [INDEX_BITS:0]   row_inc;
  logic                  mend;
  logic                  wrap;
  logic [INDEX_BITS-1:0] row_closed;
  logic [COUNT_BITS-1:0] c1, c2;
  logic                  seen_now;

  always_comb begin
    if (num_rows_r == '0) begin
      eff_rows = ROWS_ONE;
    end else if (num_rows_r > ROWS_MAX) begin
      eff_rows = ROWS_MAX;
    end else begin
      eff_rows = num_rows_r;
    end
  end

  assign row_inc    = {1'b0, row_r} + ROWS_ONE;
  assign mend       = (row_inc == eff_rows);
  assign wrap       = (row_inc >= eff_rows);
  assign row_closed = wrap ? '0 : row_inc[INDEX_BITS-1:0];
  assign c1         = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_ONE;
  assign c2         = (c1 == CNT_MAX) ? c1 : c1 + CNT_ONE;
  assign seen_now   = seen_r | (in_col == row_r);

  // result layout: {col, row_end, pointer, matrix_end, last}
  always_comb begin
    row_nxt  = row_r;
    seen_nxt = seen_r;
    cnt_nxt  = cnt_r;
    two      = 1'b0;
    res1     = {row_r, 1'b1, c2, mend, 1'b1};
    res0     = {in_col, 1'b0, c1, 1'b0, 1'b1};
    if (cmd == csi_pkg::CMD_EMPTY) begin
      res0     = {row_r, 1'b1, c1, mend, 1'b1};
      cnt_nxt  = c1;
      row_nxt  = row_closed;
      seen_nxt = 1'b0;
    end else if (!row_last) begin
      cnt_nxt  = c1;
      seen_nxt = seen_now;
    end else if (seen_now) begin
      res0     = {in_col, 1'b1, c1, mend, 1'b1};
      cnt_nxt  = c1;
      row_nxt  = row_closed;
      seen_nxt = 1'b0;
    end else begin
      res0     = {in_col, 1'b0, c1, 1'b0, 1'b0};
      two      = 1'b1;
      cnt_nxt  = c2;
      row_nxt  = row_closed;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ROWS_ONE;
      row_r      <= '0;
      seen_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        num_rows_r <= cfg_wdata;
      end
      if (accept) begin
        row_r  <= row_nxt;
        seen_r <= seen_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

endmodule

// ----- rtl/csi_outq.sv -----
// csi_outq: two-slot result buffer; slot 0 drives the output, slot 1 holds an
// appended diagonal. Depends on nothing.
module csi_outq #(
  parameter int unsigned DATA_W = 43
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              push_two,
  input  logic [DATA_W-1:0] d0,
  input  logic [DATA_W-1:0] d1,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              v0_r, v1_r;
  logic [DATA_W-1:0] s0_r, s1_r;
  logic              pop;

  assign pop       = v0_r && out_ready;
  assign can_push  = !v1_r && (!v0_r || out_ready);
  assign out_valid = v0_r;
  assign out_data  = s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (push) begin
      v0_r <= 1'b1;
      v1_r <= push_two;
    end else if (pop) begin
      v0_r <= v1_r;
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s0_r <= d0;
      s1_r <= d1;
    end else if (pop) begin
      s0_r <= s1_r;
    end
  end

endmodule

// ----- rtl/csr_self_loop_insert.sv -----
// csr_self_loop_insert: streaming CSR A+I builder, top level.
// Results are registered and valid in the cycle after the input transaction is accepted.
// Throughput: one item per cycle while the output accepts results; an item that appends a diagonal emits two
// results and holds the input off until the spare slot drains.
// Synchronous active-low reset clears row state, count and buffer; num_rows = 1.
// Depends on csi_pkg, csi_if, csi_core, csi_outq.
module csr_self_loop_insert #(
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [INDEX_BITS:0] cfg_wdata,
  csi_in_if.sink              in_ch,
  csi_out_if.source           out_ch
);

  localparam int unsigned RES_W = INDEX_BITS + COUNT_BITS + 3;

  logic             accept;
  logic             can_push;
  logic             two;
  logic [RES_W-1:0] res0, res1;
  logic [RES_W-1:0] q_data;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  csi_core #(
    .INDEX_BITS (INDEX_BITS),
    .COUNT_BITS (COUNT_BITS),
    .RES_W      (RES_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd       (in_ch.cmd),
    .in_col    (in_ch.col),
    .row_last  (in_ch.row_last),
    .res0      (res0),
    .res1      (res1),
    .two       (two)
  );

  csi_outq #(
    .DATA_W (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_two  (two),
    .d0        (res0),
    .d1        (res1),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (q_data)
  );

  assign out_ch.out_col     = q_data[RES_W-1 -: INDEX_BITS];
  assign out_ch.row_end     = q_data[COUNT_BITS+2];
  assign out_ch.row_pointer = q_data[COUNT_BITS+1:2];
  assign out_ch.matrix_end  = q_data[1];
  assign out_ch.last        = q_data[0];

endmodule
